>>> rtl/ppdc_pkg.sv
// package: payload types, action codes and widths for the pwm capture block
`timescale 1ns / 1ps
package ppdc_pkg;
    localparam int CAPTURE_BITS = 16;
    localparam int STAMP_BITS   = 32 + CAPTURE_BITS;
    localparam int CFG_BITS     = 28;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [2:0] {
        ACT_CAPTURE = 3'd0,
        ACT_WRAP    = 3'd1,
        ACT_OVERRUN = 3'd2,
        ACT_REPORT  = 3'd3,
        ACT_RESTART = 3'd4
    } t_action;

    localparam logic [2:0] CFG_CLOCK = 3'd0;
    localparam logic [2:0] CFG_FMIN  = 3'd1;
    localparam logic [2:0] CFG_FMAX  = 3'd2;
    localparam logic [2:0] CFG_TMO   = 3'd3;
    localparam logic [2:0] CFG_INV   = 3'd4;

    localparam logic [1:0] ST_SEARCH = 2'd0;
    localparam logic [1:0] ST_LOW    = 2'd1;
    localparam logic [1:0] ST_HIGH   = 2'd2;
    localparam logic [1:0] ST_OK     = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] capture_value;
        logic        wrap_pending;
        logic        pin_level;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] frequency;
        logic [13:0] duty_hundredths;
        logic [31:0] period_cnt;
        logic [31:0] high_ticks;
        logic [31:0] age_ms;
        logic [31:0] overrun_count;
        logic        synced;
        logic        raw_pin;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // register accepted beat
        logic edge_eval; // compute stamp/period/high
        logic div_start; // start divider
        logic div_sel;   // 0 frequency, 1 duty
        logic commit;    // apply state update of the beat
        logic meas_ok;   // measurement accepted
        logic rep_fill;  // write result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic need_meas; // rising edge with both edges known
        logic pre_ok;    // period/high checks without frequency
        logic freq_ok;   // last frequency quotient inside range
    } t_stat;
endpackage

>>> rtl/ppdc_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ppdc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    import ppdc_pkg::*;
    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    assign w_trial = {r_rem[31:0], r_quo[63]};
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                if (!w_diff[32]) begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;
endmodule

>>> rtl/ppdc_datapath.sv
// datapath: configuration, edge state, measurement latch and report result
`timescale 1ns / 1ps
module ppdc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [27:0]           i_cfg_data,
    input  ppdc_pkg::t_in         i_item,
    input  ppdc_pkg::t_cmd        i_cmd,
    output ppdc_pkg::t_stat       o_stat,
    output ppdc_pkg::t_out        o_res
);
    import ppdc_pkg::*;

    logic [27:0] r_clk_hz;
    logic [19:0] r_fmin, r_fmax, r_tmo;
    logic        r_inv;

    t_in         r_it;
    logic [31:0] r_wraps;
    logic        r_expf, r_rise, r_fall, r_mvalid, r_msync;
    logic [STAMP_BITS-1:0] r_rstamp, r_fstamp, r_ts;
    logic [31:0] r_overruns, r_lper, r_lhigh, r_ltime;
    // top bit is the borrow of the stamp difference
    logic [STAMP_BITS:0] r_per, r_high;
    logic [63:0] r_freq;
    logic        r_freq_ok;

    logic [31:0] w_wraps;
    logic [STAMP_BITS-1:0] w_ts;
    logic [31:0] w_age;
    logic [31:0] w_h;
    logic [63:0] w_num;
    logic [31:0] w_den;
    logic        w_done;
    logic [63:0] w_quo;
    logic [63:0] w_fmin_m, w_fmax_m;
    t_out        n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= 28'd1000000;
            r_fmin   <= 20'd1;
            r_fmax   <= 20'd5000;
            r_tmo    <= 20'd2500;
            r_inv    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLOCK: r_clk_hz <= i_cfg_data;
                CFG_FMIN:  r_fmin   <= i_cfg_data[19:0];
                CFG_FMAX:  r_fmax   <= i_cfg_data[19:0];
                CFG_TMO:   r_tmo    <= i_cfg_data[19:0];
                CFG_INV:   r_inv    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // capture widened with the wrap count; a pending wrap counts below half range
    assign w_wraps = (r_it.wrap_pending && !r_it.capture_value[CAPTURE_BITS-1])
                     ? r_wraps + 32'd1 : r_wraps;
    assign w_ts  = {w_wraps, r_it.capture_value[CAPTURE_BITS-1:0]};
    assign w_age = (r_it.now_ms >= r_ltime) ? r_it.now_ms - r_ltime : 32'd0;
    assign w_h   = r_inv ? r_lper - r_lhigh : r_lhigh;

    assign w_num = i_cmd.div_sel
                 ? ({32'd0, w_h} * 64'd10000) + {33'd0, r_lper[31:1]}
                 : {36'd0, r_clk_hz} * 64'd1000;
    assign w_den = i_cmd.div_sel ? r_lper
                 : (r_it.action == ACT_REPORT ? r_lper : r_per[31:0]);

    ppdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    assign w_fmin_m = {44'd0, r_fmin} * 64'd1000;
    assign w_fmax_m = {44'd0, r_fmax} * 64'd1000;

    always_comb begin
        n_res = '0;
        n_res.age_ms        = w_age;
        n_res.overrun_count = r_overruns;
        n_res.raw_pin       = r_it.pin_level;
        if (w_age > {12'd0, r_tmo}) begin
            n_res.status = (r_it.pin_level != r_inv) ? ST_HIGH : ST_LOW;
        end else if (r_mvalid && r_msync) begin
            n_res.status     = ST_OK;
            n_res.synced     = 1'b1;
            n_res.period_cnt = r_lper;
            n_res.high_ticks = w_h;
            if (r_lper != 32'd0) begin
                n_res.frequency = (r_freq[63:32] != 32'd0)
                                  ? 32'hFFFF_FFFF : r_freq[31:0];
                n_res.duty_hundredths = (w_quo > 64'd10000)
                                        ? 14'd10000 : w_quo[13:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wraps <= '0; r_expf <= 1'b0; r_rise <= 1'b0; r_fall <= 1'b0;
            r_mvalid <= 1'b0; r_msync <= 1'b0; r_overruns <= '0; r_ltime <= '0;
        end else begin
            if (i_cmd.load) r_it <= i_item;
            if (i_cmd.edge_eval) begin
                r_ts   <= w_ts;
                r_per  <= {1'b0, w_ts} - {1'b0, r_rstamp};
                r_high <= {1'b0, w_ts} - {1'b0, r_fstamp};
            end
            // frequency quotient; the duty quotient is read directly at fill
            if (w_done && !i_cmd.rep_fill) begin
                r_freq    <= w_quo;
                r_freq_ok <= (w_quo >= w_fmin_m) && (w_quo <= w_fmax_m);
            end
            if (i_cmd.commit) begin
                case (r_it.action)
                    ACT_CAPTURE: begin
                        if (!r_expf) begin
                            if (r_rise && r_fall) begin
                                if (i_cmd.meas_ok) begin
                                    r_lper   <= r_per[31:0];
                                    r_lhigh  <= r_high[31:0];
                                    r_ltime  <= r_it.now_ms;
                                    r_mvalid <= 1'b1;
                                    r_msync  <= 1'b1;
                                end else begin
                                    r_msync <= 1'b0;
                                end
                            end
                            r_rstamp <= r_ts;
                            r_rise   <= 1'b1;
                            r_expf   <= 1'b1;
                        end else begin
                            r_fstamp <= r_ts;
                            r_fall   <= 1'b1;
                            r_expf   <= 1'b0;
                        end
                    end
                    ACT_WRAP: r_wraps <= r_wraps + 32'd1;
                    ACT_OVERRUN: begin
                        r_overruns <= r_overruns + 32'd1;
                        r_rise <= 1'b0; r_fall <= 1'b0; r_msync <= 1'b0;
                        r_expf <= r_it.pin_level;
                    end
                    ACT_RESTART: begin
                        r_wraps <= '0; r_rise <= 1'b0; r_fall <= 1'b0;
                        r_overruns <= '0; r_mvalid <= 1'b0; r_msync <= 1'b0;
                        r_expf <= r_it.pin_level;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.rep_fill) o_res <= n_res;
        end
    end

    assign o_stat.div_done  = w_done;
    assign o_stat.need_meas = (r_it.action == ACT_CAPTURE) && !r_expf && r_rise && r_fall;
    assign o_stat.pre_ok    = (r_per != '0) && (r_per[STAMP_BITS:32] == '0)
                              && (r_high <= r_per);
    assign o_stat.freq_ok   = r_freq_ok;
endmodule

>>> rtl/ppdc_ctrl.sv
// controller: evaluates each beat, divides if needed, commits or outputs
`timescale 1ns / 1ps
module ppdc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  logic [2:0]        i_action,
    input  ppdc_pkg::t_stat   i_stat,
    output ppdc_pkg::t_cmd    o_cmd
);
    import ppdc_pkg::*;
    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_CHECK, S_FWAIT, S_COMMIT, S_RFREQ, S_RDUTY, S_OUT
    } t_state;
    t_state r_state;
    logic   r_ok;
    logic [2:0] r_act;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.load = o_ready && i_valid;
        unique case (r_state)
            S_EVAL:   o_cmd.edge_eval = 1'b1;
            S_CHECK:  o_cmd.div_start = i_stat.need_meas && i_stat.pre_ok;
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                o_cmd.meas_ok = r_ok && i_stat.freq_ok;
            end
            S_RDUTY:  begin
                o_cmd.div_sel = 1'b1;
                o_cmd.rep_fill = i_stat.div_done;
            end
            S_RFREQ:  o_cmd.div_start = 1'b0;
            default: ;
        endcase
        if (r_state == S_EVAL && r_act == ACT_REPORT) begin
            o_cmd.edge_eval = 1'b0;
            o_cmd.div_start = 1'b1;
        end
        if (r_state == S_RFREQ && i_stat.div_done) begin
            o_cmd.div_start = 1'b1;
            o_cmd.div_sel = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_act   <= i_action;
                    r_state <= S_EVAL;
                end
                S_EVAL: r_state <= (r_act == ACT_REPORT) ? S_RFREQ : S_CHECK;
                S_CHECK: begin
                    r_ok <= 1'b0;
                    if (i_stat.need_meas && i_stat.pre_ok) r_state <= S_FWAIT;
                    else r_state <= S_COMMIT;
                end
                S_FWAIT: if (i_stat.div_done) r_state <= S_COMMIT;
                S_COMMIT: begin
                    r_state <= S_IDLE;
                end
                S_RFREQ: if (i_stat.div_done) r_state <= S_RDUTY;
                S_RDUTY: if (i_stat.div_done) begin
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_FWAIT && i_stat.div_done) r_ok <= 1'b1;
        end
    end
endmodule

>>> rtl/pwm_period_duty_capture.sv
// top level: pwm period and duty capture block
// capture beats return to accept after commit, a checked period after a frequency division
// report beats run a frequency and then a duty division from accept to a valid result
// one beat in flight at a time; result held in an output register
// the shared divider produces one quotient bit per cycle
// reset (synchronous, active low) restores default registers and clears edge state
`timescale 1ns / 1ps
module pwm_period_duty_capture (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ppdc_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output ppdc_pkg::t_out  o_data,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [27:0]     i_cfg_data
);
    import ppdc_pkg::*;
    t_cmd  w_cmd;
    t_stat w_stat;

    ppdc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_action(i_data.action),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    ppdc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .i_item(i_data),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_res(o_data)
    );
endmodule

>>> bench/tb_pwm_period_duty_capture.sv
// testbench: pwm period and duty capture block against a cycle-free predictor
`timescale 1ns / 1ps
module tb_pwm_period_duty_capture;
    import ppdc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [27:0] i_cfg_data = '0;

    pwm_period_duty_capture dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [27:0] clk_hz;
    logic [19:0] fmin_hz, fmax_hz, tmo_ms;
    logic        inv;
    logic [31:0] wraps;
    logic        want_fall, have_rise, have_fall;
    logic [47:0] rise_ts, fall_ts;
    logic [31:0] ovr_cnt, lat_period, lat_high, lat_ms;
    logic        meas_valid, meas_synced;

    t_out        report_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          no_idle = 0;
    localparam int CYCLE_LIMIT = 3000000;

    function automatic bit freq_in_range(logic [63:0] period);
        logic [63:0] f;
        if (period == 0) return 0;
        f = 64'(clk_hz) * 1000 / period;
        return f >= 64'(fmin_hz) * 1000 && f <= 64'(fmax_hz) * 1000;
    endfunction

    task automatic pwm_predict(input t_in it);
        logic [63:0] w, ts, per, hi, p, h, f, d;
        t_out r;
        case (it.action)
            ACT_CAPTURE: begin
                w = 64'(wraps);
                if (it.wrap_pending && it.capture_value < 16'h8000) w = 64'(32'(w + 1));
                ts = (w << CAPTURE_BITS) | 64'(it.capture_value);
                if (!want_fall) begin
                    if (have_rise && have_fall) begin
                        per = ts - 64'(rise_ts);
                        hi = ts - 64'(fall_ts);
                        if (per > 0 && per < 64'h1_0000_0000 && hi <= per && freq_in_range(per)) begin
                            lat_period = per[31:0];
                            lat_high = hi[31:0];
                            lat_ms = it.now_ms;
                            meas_valid = 1;
                            meas_synced = 1;
                        end else begin
                            meas_synced = 0;
                        end
                    end
                    rise_ts = ts[47:0];
                    have_rise = 1;
                    want_fall = 1;
                end else begin
                    fall_ts = ts[47:0];
                    have_fall = 1;
                    want_fall = 0;
                end
            end
            ACT_WRAP: wraps = wraps + 1;
            ACT_OVERRUN: begin
                ovr_cnt = ovr_cnt + 1;
                have_rise = 0;
                have_fall = 0;
                meas_synced = 0;
                want_fall = it.pin_level;
            end
            ACT_REPORT: begin
                r = '0;
                r.age_ms = (it.now_ms >= lat_ms) ? it.now_ms - lat_ms : 32'd0;
                r.overrun_count = ovr_cnt;
                r.raw_pin = it.pin_level;
                if (r.age_ms > 32'(tmo_ms)) begin
                    r.status = (it.pin_level != inv) ? ST_HIGH : ST_LOW;
                end else if (!meas_valid || !meas_synced) begin
                    r.status = ST_SEARCH;
                end else begin
                    p = 64'(lat_period);
                    h = inv ? p - 64'(lat_high) : 64'(lat_high);
                    f = 0;
                    d = 0;
                    if (p != 0) begin
                        f = 64'(clk_hz) * 1000 / p;
                        d = (h * 10000 + p / 2) / p;
                    end
                    if (f > 64'hFFFF_FFFF) f = 64'hFFFF_FFFF;
                    if (d > 10000) d = 10000;
                    r.status = ST_OK;
                    r.frequency = f[31:0];
                    r.duty_hundredths = d[13:0];
                    r.period_cnt = p[31:0];
                    r.high_ticks = h[31:0];
                    r.synced = 1;
                end
                report_q.push_back(r);
            end
            ACT_RESTART: begin
                wraps = 0;
                have_rise = 0;
                have_fall = 0;
                ovr_cnt = 0;
                meas_valid = 0;
                meas_synced = 0;
                want_fall = it.pin_level;
            end
            default: ;
        endcase
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [27:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CLOCK: clk_hz = val;
            CFG_FMIN:  fmin_hz = val[19:0];
            CFG_FMAX:  fmax_hz = val[19:0];
            CFG_TMO:   tmo_ms = val[19:0];
            CFG_INV:   inv = val[0];
            default: ;
        endcase
    endtask

    // valid stays up between back-to-back beats and drops only for an idle burst or a drain
    task automatic send_beat(input t_in it);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pwm_predict(it);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // receiver with random stall bursts, always ready in the no-idle phase
    int stall_left = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (report_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) $display("unexpected result beat %p", o_data);
                end else begin
                    if (o_data !== report_q[0]) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", report_q[0], o_data);
                    end
                    void'(report_q.pop_front());
                end
            end
            if (no_idle) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 12) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_in mk(input logic [2:0] a, input logic [15:0] c, input logic w,
                               input logic p, input logic [31:0] n);
        t_in t;
        t.action = a;
        t.capture_value = c;
        t.wrap_pending = w;
        t.pin_level = p;
        t.now_ms = n;
        return t;
    endfunction

    // one pwm cycle of well-formed captures, with wrap beats where the counter wraps
    logic [31:0] now_clk = 0;
    logic [15:0] cnt_pos = 0;
    task automatic pwm_cycle(input int per, input int hi);
        int lo;
        lo = per - hi;
        now_clk = now_clk + $urandom_range(0, 3);
        send_beat(mk(ACT_CAPTURE, cnt_pos, 1'b0, 1'b0, now_clk));
        if (32'(cnt_pos) + 32'(hi) > 32'hFFFF) send_beat(mk(ACT_WRAP, 0, 0, 0, now_clk));
        cnt_pos = cnt_pos + 16'(hi);
        send_beat(mk(ACT_CAPTURE, cnt_pos, 1'($urandom_range(0, 1)), 1'b1, now_clk));
        if (32'(cnt_pos) + 32'(lo) > 32'hFFFF) send_beat(mk(ACT_WRAP, 0, 0, 0, now_clk));
        cnt_pos = cnt_pos + 16'(lo);
    endtask

    typedef struct {
        t_in  it;
        bit   has_exp;
        logic [1:0] st;
    } t_row;

    initial begin
        t_row rows[$];
        t_in  it;
        logic [63:0] rnd;
        int   n, k, per, hi;
        clk_hz = 1000000; fmin_hz = 1; fmax_hz = 5000; tmo_ms = 2500; inv = 0;
        wraps = 0; want_fall = 0; have_rise = 0; have_fall = 0;
        rise_ts = 0; fall_ts = 0; ovr_cnt = 0; lat_period = 0; lat_high = 0;
        lat_ms = 0; meas_valid = 0; meas_synced = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: expected status only where obvious
        rows.push_back('{mk(ACT_REPORT, 0, 0, 0, 0), 1, ST_SEARCH});
        rows.push_back('{mk(ACT_REPORT, 0, 0, 1, 32'hFFFF_FFFF), 1, ST_HIGH});
        rows.push_back('{mk(ACT_REPORT, 0, 0, 0, 32'hFFFF_FFFF), 1, ST_LOW});
        rows.push_back('{mk(ACT_CAPTURE, 16'h0000, 0, 1, 10), 0, 0});
        rows.push_back('{mk(ACT_CAPTURE, 16'h0100, 0, 0, 10), 0, 0});
        rows.push_back('{mk(ACT_CAPTURE, 16'h0400, 0, 1, 10), 0, 0});
        rows.push_back('{mk(ACT_REPORT, 0, 0, 1, 11), 0, 0});
        rows.push_back('{mk(ACT_WRAP, 0, 0, 0, 12), 0, 0});
        rows.push_back('{mk(ACT_CAPTURE, 16'hFFFF, 1, 0, 12), 0, 0});
        rows.push_back('{mk(ACT_CAPTURE, 16'h0010, 1, 1, 12), 0, 0});
        rows.push_back('{mk(ACT_REPORT, 0, 0, 0, 13), 0, 0});
        rows.push_back('{mk(ACT_CAPTURE, 16'h0010, 0, 0, 14), 0, 0});
        rows.push_back('{mk(ACT_CAPTURE, 16'h0010, 0, 1, 14), 0, 0});
        rows.push_back('{mk(ACT_REPORT, 0, 0, 1, 5), 0, 0});
        rows.push_back('{mk(ACT_OVERRUN, 0, 0, 1, 15), 0, 0});
        rows.push_back('{mk(ACT_REPORT, 0, 0, 1, 15), 0, 0});
        rows.push_back('{mk(3'd5, 16'hFFFF, 1, 1, 15), 0, 0});
        rows.push_back('{mk(3'd7, 16'hFFFF, 1, 1, 15), 0, 0});
        rows.push_back('{mk(ACT_RESTART, 0, 0, 1, 16), 0, 0});
        rows.push_back('{mk(ACT_REPORT, 0, 0, 0, 16), 0, 0});
        foreach (rows[i]) begin
            send_beat(rows[i].it);
            if (rows[i].has_exp && report_q[$].status !== rows[i].st) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("row %0d status table %0d", i, rows[i].st);
            end
        end
        drain();

        // random phases across register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin cfg_write(CFG_CLOCK, 28'd1); cfg_write(CFG_FMIN, 0);
                   cfg_write(CFG_FMAX, 20'd1000000); cfg_write(CFG_TMO, 0); end
                1: begin cfg_write(CFG_CLOCK, 28'd200000000); cfg_write(CFG_FMAX, 20'hFFFFF);
                   cfg_write(CFG_TMO, 20'hFFFFF); cfg_write(CFG_INV, 1); end
                2: begin cfg_write(CFG_CLOCK, 28'hFFFFFFF); cfg_write(CFG_FMIN, 20'd1000000);
                   cfg_write(CFG_INV, 0); end
                3: begin cfg_write(CFG_CLOCK, 28'd1000000); cfg_write(CFG_FMIN, 20'd20);
                   cfg_write(CFG_FMAX, 20'd2000); cfg_write(CFG_TMO, 20'd50); end
                4: begin cfg_write(CFG_CLOCK, 28'($urandom)); cfg_write(CFG_FMIN, 20'($urandom_range(0, 50)));
                   cfg_write(CFG_FMAX, 20'($urandom)); cfg_write(CFG_INV, 1); end
                default: begin no_idle = 1; cfg_write(CFG_CLOCK, 28'd1000000);
                   cfg_write(CFG_FMIN, 1); cfg_write(CFG_FMAX, 5000); cfg_write(CFG_TMO, 2500);
                   cfg_write(CFG_INV, 0); end
            endcase
            send_beat(mk(ACT_RESTART, 0, 0, 0, now_clk));
            n = 0;
            while (n < 280) begin
                k = $urandom_range(0, 9);
                if (k < 6) begin
                    per = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200000) : $urandom_range(2, 3000);
                    hi = $urandom_range(0, per);
                    pwm_cycle(per, hi);
                    n += 2;
                    if ($urandom_range(0, 2) == 0) begin
                        send_beat(mk(ACT_REPORT, 0, 0, 1'($urandom), now_clk + $urandom_range(0, 60)));
                        n++;
                    end
                end else begin
                    rnd = {$urandom, $urandom};
                    it = rnd[$bits(t_in)-1:0];
                    if ($urandom_range(0, 1)) it.action = ACT_REPORT;
                    send_beat(it);
                    n++;
                end
            end
            drain();
        end

        if (mismatches == 0 && report_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
